// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the energy power meter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ECPM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication checked at every clock edge outside reset.
`define ECPM_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ecpm_pkg.sv -----
// Package with the shared constants and types of the energy power meter.
`timescale 1ns / 1ps
package ecpm_pkg;

   // Domains and field widths.
   localparam int DOMAIN_COUNT = 5;
   localparam int DOM_W        = 3;
   localparam int DOM_IDX_W    = (DOMAIN_COUNT > 1) ? $clog2(DOMAIN_COUNT) : 1;
   localparam int COUNT_W      = 32;
   localparam int TIME_W       = 48;
   localparam int EXP_W        = 5;
   localparam int ENERGY_W     = 64;
   localparam int POWER_W      = 32;

   // Arithmetic widths: product of delta and 10^6, numerator, denominator, remainder, step count.
   localparam int PROD_W = 52;
   localparam int NUM_W  = PROD_W + 16;
   localparam int DEN_W  = TIME_W + 15;
   localparam int REM_W  = DEN_W + 1;
   localparam int STEP_W = $clog2(POWER_W);

   localparam logic [DOM_W-1:0]  DRAM_DOMAIN    = 3'd3;
   localparam logic [EXP_W-1:0]  DRAM_EXPONENT  = 5'd16;
   localparam logic [EXP_W-1:0]  EXPONENT_RESET = 5'd14;
   localparam logic [PROD_W-1:0] US_PER_S       = PROD_W'(1000000);

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [0:0] {
      REG_ENERGY_EXPONENT = 1'b0,
      REG_DRAM_FIXED_UNIT = 1'b1
   } reg_idx_type;

   typedef struct packed {
      logic [EXP_W-1:0] energy_exponent;
      logic             dram_fixed_unit;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- rtl/energy_counter_power_meter_core.sv -----
// Top level of the energy power meter: domain store, sequencer and output register.
// A word goes through the load, multiply and prepare steps; unless no time passed, prepare
// starts the power division, and the finish step fills the output register. A first or
// out-of-range reading yields no result. Words are taken only while idle; the divider gives
// one quotient bit per cycle after an overflow check; a waiting result holds the finish step.
// Reset clears the sequencer, the primed bits of all domains and the configuration.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module energy_counter_power_meter_core (
   input  logic                             clock,
   input  logic                             reset,
   // Input words.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [79:0]                      req_tdata,  // counter[31:0], time_us[79:32]
   input  logic [2:0]                       req_tuser,  // domain[2:0]
   // Result words.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [143:0]                     rsp_tdata,  // energy_q32[63:0], power_q16[95:64],
                                                        // elapsed_us[143:96]
   output logic [2:0]                       rsp_tuser,  // out_domain[2:0]
   // Configuration port.
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ecpm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ecpm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ecpm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_LOAD = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_PREP = 6'b001000,
      ST_WAIT = 6'b010000,
      ST_FIN  = 6'b100000
   } seq_state_type;

   localparam int DC  = ecpm_pkg::DOMAIN_COUNT;
   localparam int CW  = ecpm_pkg::COUNT_W;
   localparam int TW  = ecpm_pkg::TIME_W;
   localparam int EW  = ecpm_pkg::EXP_W;
   localparam int RSP_W = ecpm_pkg::ENERGY_W + ecpm_pkg::POWER_W + TW;

   ecpm_pkg::cfg_type        cfg;
   ecpm_pkg::div_status_type div_stat;
   logic [ecpm_pkg::POWER_W-1:0] div_quo;
   logic                     div_start;
   logic [ecpm_pkg::NUM_W-1:0] div_num;
   logic [ecpm_pkg::DEN_W-1:0] div_den;

   seq_state_type                 state_ff, state_in;
   logic [ecpm_pkg::DOM_W-1:0]    dom_ff, dom_in;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [TW-1:0]                 now_ff, now_in;
   logic [CW-1:0]                 delta_ff, delta_in;
   logic [TW-1:0]                 elapsed_ff, elapsed_in;
   logic [EW-1:0]                 exp_ff, exp_in;
   logic [ecpm_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic [ecpm_pkg::ENERGY_W-1:0] energy_ff, energy_in;
   logic [ecpm_pkg::POWER_W-1:0]  power_ff, power_in;
   logic [CW-1:0]                 last_count_ff [DC];
   logic [CW-1:0]                 last_count_in [DC];
   logic [TW-1:0]                 last_time_ff [DC];
   logic [TW-1:0]                 last_time_in [DC];
   logic [DC-1:0]                 primed_ff, primed_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]              rsp_data_ff, rsp_data_in;
   logic [ecpm_pkg::DOM_W-1:0]    rsp_dom_ff, rsp_dom_in;
   logic [ecpm_pkg::DOM_IDX_W-1:0] dom_idx;
   logic                          dom_valid;

   ecpm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   ecpm_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (div_den),
      .status (div_stat),
      .quo    (div_quo)
   );

   assign dom_idx   = dom_ff[ecpm_pkg::DOM_IDX_W-1:0];
   assign dom_valid = (ecpm_pkg::DOM_W + 1)'(dom_ff) < (ecpm_pkg::DOM_W + 1)'(DC);
   assign req_tready = (state_ff == ST_IDLE);

   // Scale numerator or denominator so that both exponent ranges share one division.
   always_comb begin
      if (exp_ff <= ecpm_pkg::DRAM_EXPONENT) begin
         div_num = ecpm_pkg::NUM_W'(prod_ff) << (ecpm_pkg::DRAM_EXPONENT - exp_ff);
         div_den = ecpm_pkg::DEN_W'(elapsed_ff);
      end else begin
         div_num = ecpm_pkg::NUM_W'(prod_ff);
         div_den = ecpm_pkg::DEN_W'(elapsed_ff) << (exp_ff - ecpm_pkg::DRAM_EXPONENT);
      end
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      dom_in        = dom_ff;
      cnt_in        = cnt_ff;
      now_in        = now_ff;
      delta_in      = delta_ff;
      elapsed_in    = elapsed_ff;
      exp_in        = exp_ff;
      prod_in       = prod_ff;
      energy_in     = energy_ff;
      power_in      = power_ff;
      last_count_in = last_count_ff;
      last_time_in  = last_time_ff;
      primed_in     = primed_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_dom_in    = rsp_dom_ff;
      div_start     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dom_in   = req_tuser;
               cnt_in   = req_tdata[CW-1:0];
               now_in   = req_tdata[CW+TW-1:CW];
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // Unknown domains are dropped; a first reading only primes the domain.
            if (!dom_valid) begin
               state_in = ST_IDLE;
            end else begin
               delta_in   = cnt_ff - last_count_ff[dom_idx];
               elapsed_in = now_ff - last_time_ff[dom_idx];
               exp_in     = (dom_ff == ecpm_pkg::DRAM_DOMAIN && cfg.dram_fixed_unit) ?
                            ecpm_pkg::DRAM_EXPONENT : cfg.energy_exponent;
               last_count_in[dom_idx] = cnt_ff;
               last_time_in[dom_idx]  = now_ff;
               primed_in[dom_idx]     = 1'b1;
               state_in = primed_ff[dom_idx] ? ST_MUL : ST_IDLE;
            end
         end
         ST_MUL: begin
            prod_in   = ecpm_pkg::PROD_W'(delta_ff) * ecpm_pkg::US_PER_S;
            energy_in = ecpm_pkg::ENERGY_W'(delta_ff) << (6'd32 - 6'(exp_ff));
            state_in  = ST_PREP;
         end
         ST_PREP: begin
            if (elapsed_ff == '0) begin
               power_in = '0;
               state_in = ST_FIN;
            end else begin
               div_start = 1'b1;
               state_in  = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (div_stat.done) begin
               power_in = div_quo;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            // Hand the result to the output register once it is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {elapsed_ff, power_ff, energy_ff};
               rsp_dom_in   = dom_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         primed_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dom_ff        <= dom_in;
      cnt_ff        <= cnt_in;
      now_ff        <= now_in;
      delta_ff      <= delta_in;
      elapsed_ff    <= elapsed_in;
      exp_ff        <= exp_in;
      prod_ff       <= prod_in;
      energy_ff     <= energy_in;
      power_ff      <= power_in;
      last_count_ff <= last_count_in;
      last_time_ff  <= last_time_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_dom_ff    <= rsp_dom_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_dom_ff;

   // The divider only runs while the sequencer waits for it.
   `ECPM_ASSERT_IMPL(a_div_in_wait, div_stat.busy, state_ff == ST_WAIT, "divider busy")
   // A new result word appears only after the finish step.
   `ECPM_ASSERT_IMPL(a_rsp_from_fin, $rose(rsp_valid_ff), $past(state_ff == ST_FIN), "no finish")
   // The divider reports completion only to a waiting sequencer.
   `ECPM_ASSERT_IMPL(a_done_in_wait, div_stat.done, state_ff == ST_WAIT, "stray divider done")

endmodule

// ----- rtl/ecpm_csr.sv -----
// Configuration registers of the energy power meter behind an APB-style port.
`timescale 1ns / 1ps
module ecpm_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [ecpm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [ecpm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [ecpm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready,
   output ecpm_pkg::cfg_type                cfg
);

   ecpm_pkg::cfg_type     cfg_ff;
   ecpm_pkg::cfg_type     cfg_in;
   ecpm_pkg::reg_idx_type reg_idx;
   logic                  wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = ecpm_pkg::reg_idx_type'(csr_paddr[ecpm_pkg::CSR_ADDR_W-1:2]);

   // Register writes; the byte offset within a word is ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            ecpm_pkg::REG_ENERGY_EXPONENT: begin
               cfg_in.energy_exponent = csr_pwdata[ecpm_pkg::EXP_W-1:0];
            end
            ecpm_pkg::REG_DRAM_FIXED_UNIT: begin
               cfg_in.dram_fixed_unit = csr_pwdata[0];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.energy_exponent <= ecpm_pkg::EXPONENT_RESET;
         cfg_ff.dram_fixed_unit <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data.
   always_comb begin
      unique case (reg_idx)
         ecpm_pkg::REG_ENERGY_EXPONENT: begin
            csr_prdata = ecpm_pkg::CSR_DATA_W'(cfg_ff.energy_exponent);
         end
         ecpm_pkg::REG_DRAM_FIXED_UNIT: begin
            csr_prdata = ecpm_pkg::CSR_DATA_W'(cfg_ff.dram_fixed_unit);
         end
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/ecpm_div.sv -----
// Iterative restoring divider with 32-bit saturating quotient, one bit per cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ecpm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ecpm_pkg::NUM_W-1:0]    num,
   input  logic [ecpm_pkg::DEN_W-1:0]    den,
   output ecpm_pkg::div_status_type      status,
   output logic [ecpm_pkg::POWER_W-1:0]  quo
);

   typedef enum logic [2:0] {
      DV_IDLE  = 3'b001,
      DV_CHECK = 3'b010,
      DV_STEP  = 3'b100
   } div_state_type;

   localparam int REM_W = ecpm_pkg::REM_W;
   localparam int QW    = ecpm_pkg::POWER_W;

   div_state_type                state_ff, state_in;
   logic                         done_ff, done_in;
   logic [REM_W-1:0]             rem_ff, rem_in;
   logic [QW-1:0]                low_ff, low_in;
   logic [ecpm_pkg::DEN_W-1:0]   den_ff, den_in;
   logic [QW-1:0]                quo_ff, quo_in;
   logic [ecpm_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [REM_W-1:0]             cand;
   logic [REM_W:0]               diff;
   logic                         ge;

   // Shared subtractor: the overflow check first, then one quotient bit a cycle.
   assign cand = (state_ff == DV_CHECK) ? rem_ff : {rem_ff[REM_W-2:0], low_ff[QW-1]};
   assign diff = {1'b0, cand} - (REM_W + 1)'(den_ff);
   assign ge   = !diff[REM_W];

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      rem_in   = rem_ff;
      low_in   = low_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               rem_in   = REM_W'(num[ecpm_pkg::NUM_W-1:QW]);
               low_in   = num[QW-1:0];
               den_in   = den;
               quo_in   = '0;
               state_in = DV_CHECK;
            end
         end
         DV_CHECK: begin
            // Upper part of the numerator at or above the divisor: quotient overflows.
            if (ge) begin
               quo_in   = '1;
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end else begin
               step_in  = ecpm_pkg::STEP_W'(QW - 1);
               state_in = DV_STEP;
            end
         end
         DV_STEP: begin
            rem_in = ge ? diff[REM_W-1:0] : cand;
            low_in = {low_ff[QW-2:0], 1'b0};
            quo_in = {quo_ff[QW-2:0], ge};
            if (step_ff == '0) begin
               done_in  = 1'b1;
               state_in = DV_IDLE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         default: begin
            state_in = DV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign status.busy = (state_ff != DV_IDLE);
   assign status.done = done_ff;
   assign quo         = quo_ff;

   // The partial remainder stays below the divisor while bits are produced.
   `ECPM_ASSERT_IMPL(a_rem_lt_den, state_ff == DV_STEP, rem_ff < REM_W'(den_ff), "bad remainder")
   // A new division starts only when the unit is free.
   `ECPM_ASSERT_IMPL(a_start_idle, start, state_ff == DV_IDLE, "divider started while busy")

endmodule
